// ----- hw/rtl/yqc_pkg.sv -----
// ----------------------------------------------------------------------------
// yqc_pkg
// Shared types, reason codes and character helpers for the scalar quoting
// classifier.
// ----------------------------------------------------------------------------
package yqc_pkg;

   // Reason codes reported with each result word
   localparam logic [2:0] REASON_NONE    = 3'd0;
   localparam logic [2:0] REASON_EMPTY   = 3'd1;
   localparam logic [2:0] REASON_EDGE_WS = 3'd2;
   localparam logic [2:0] REASON_LEAD    = 3'd3;
   localparam logic [2:0] REASON_COLON   = 3'd4;
   localparam logic [2:0] REASON_WORD    = 3'd5;
   localparam logic [2:0] REASON_NUMERIC = 3'd6;

   localparam int WORD_COUNT = 7;

   // true, false, null, yes, no, on, off (lower case, zero padded)
   localparam logic [7:0] WORD_TEXT [WORD_COUNT][8] = '{
      '{8'h74, 8'h72, 8'h75, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h66, 8'h61, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00},
      '{8'h6e, 8'h75, 8'h6c, 8'h6c, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h79, 8'h65, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6e, 8'h6f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6f, 8'h6e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6f, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [2:0] WORD_LEN [WORD_COUNT] = '{
      3'd4, 3'd5, 3'd4, 3'd3, 3'd2, 3'd2, 3'd3
   };

   localparam logic [2:0] POS_MAX = 3'd6;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       empty_req;
   } item_type;

   typedef struct packed {
      logic       needs_quote;
      logic [2:0] reason;
   } result_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic logic is_dig(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return c == "+" || c == "-";
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return c == " " || c == 8'h09;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      logic [7:0] f;
      f = fold(c);
      return is_dig(c) || (f >= "a" && f <= "f");
   endfunction

   function automatic logic is_lead_special(input logic [7:0] c);
      return c == "?" || c == "-" || c == "*" || c == "&" || c == "!" ||
             c == "|" || c == ">" || c == "%" || c == "@";
   endfunction

endpackage

// ----- hw/rtl/yqc_scan.sv -----
// ----------------------------------------------------------------------------
// yqc_scan
// Per-scalar scan state, one character per cycle while take is high, and the
// final verdict for the character that closes the scalar.
// ----------------------------------------------------------------------------
module yqc_scan
   import yqc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  item_type   item,
   output result_type result
);

   typedef enum logic [3:0] {
      NS_START, NS_SIGN, NS_INT, NS_DOT0, NS_FRAC, NS_EXP, NS_EXPDIG,
      NS_HEX0, NS_HEX, NS_OCT0, NS_OCT, NS_SP1, NS_SP2, NS_SPD, NS_DEAD
   } num_type;

   logic                  at_start_ff, at_start_in;
   logic [7:0]            first_ff, first_in;
   logic [7:0]            prev_ff, prev_in;
   logic                  colon_ff, colon_in;
   logic [WORD_COUNT-1:0] alive_ff, alive_in;
   logic [2:0]            pos_ff, pos_in;
   num_type               num_ff, num_in;

   // state after this character (before end-of-scalar clear)
   logic                  n_at_start, n_colon;
   logic [7:0]            n_first, n_prev;
   logic [WORD_COUNT-1:0] n_alive;
   logic [2:0]            n_pos;
   num_type               n_num, num_step;

   logic       byte_take, ends, zero_lead, word_hit;
   logic [7:0] c, f, pf;

   always_comb begin
      c         = item.ch;
      f         = fold(c);
      pf        = fold(prev_ff);
      byte_take = take && !item.empty_req;
      ends      = item.last || item.empty_req;
      zero_lead = prev_ff == "0" &&
                  (pos_ff == 3'd1 || (pos_ff == 3'd2 && is_sign(first_ff)));

      case (num_ff)
         NS_START: begin
            if (is_sign(c))    num_step = NS_SIGN;
            else if (is_dig(c)) num_step = NS_INT;
            else if (c == ".")  num_step = NS_DOT0;
            else                num_step = NS_DEAD;
         end
         NS_SIGN: begin
            if (is_dig(c))     num_step = NS_INT;
            else if (c == ".") num_step = NS_DOT0;
            else               num_step = NS_DEAD;
         end
         NS_INT: begin
            if (is_dig(c))                  num_step = NS_INT;
            else if (c == ".")              num_step = NS_FRAC;
            else if (f == "e")              num_step = NS_EXP;
            else if (f == "x" && zero_lead) num_step = NS_HEX0;
            else if (f == "o" && zero_lead) num_step = NS_OCT0;
            else                            num_step = NS_DEAD;
         end
         NS_DOT0: begin
            if (is_dig(c))                 num_step = NS_FRAC;
            else if (f == "i" || f == "n") num_step = NS_SP1;
            else                           num_step = NS_DEAD;
         end
         NS_FRAC: begin
            if (is_dig(c))     num_step = NS_FRAC;
            else if (f == "e") num_step = NS_EXP;
            else               num_step = NS_DEAD;
         end
         NS_EXP: begin
            if (pf == "e" && is_sign(c)) num_step = NS_EXP;
            else if (is_dig(c))          num_step = NS_EXPDIG;
            else                         num_step = NS_DEAD;
         end
         NS_EXPDIG: begin
            num_step = is_dig(c) ? NS_EXPDIG : NS_DEAD;
         end
         NS_HEX0, NS_HEX: begin
            num_step = is_hex(c) ? NS_HEX : NS_DEAD;
         end
         NS_OCT0, NS_OCT: begin
            num_step = (c >= "0" && c <= "7") ? NS_OCT : NS_DEAD;
         end
         NS_SP1: begin
            if (pf == "i" && f == "n")      num_step = NS_SP2;
            else if (pf == "n" && f == "a") num_step = NS_SP2;
            else                            num_step = NS_DEAD;
         end
         NS_SP2: begin
            if (pf == "n" && f == "f")      num_step = NS_SPD;
            else if (pf == "a" && f == "n") num_step = NS_SPD;
            else                            num_step = NS_DEAD;
         end
         default: begin
            num_step = NS_DEAD;
         end
      endcase

      if (byte_take) begin
         n_at_start = 1'b0;
         n_first    = at_start_ff ? c : first_ff;
         n_prev     = c;
         n_colon    = colon_ff || (!at_start_ff && prev_ff == ":" && c == " ");
         n_pos      = (pos_ff < POS_MAX) ? pos_ff + 3'd1 : pos_ff;
         n_num      = num_step;
         for (int i = 0; i < WORD_COUNT; i++) begin
            n_alive[i] = alive_ff[i] && (pos_ff < WORD_LEN[i]) &&
                         (WORD_TEXT[i][pos_ff] == f);
         end
      end else begin
         n_at_start = at_start_ff;
         n_first    = first_ff;
         n_prev     = prev_ff;
         n_colon    = colon_ff;
         n_pos      = pos_ff;
         n_num      = num_ff;
         n_alive    = alive_ff;
      end

      word_hit = 1'b0;
      for (int i = 0; i < WORD_COUNT; i++) begin
         if (n_alive[i] && n_pos == WORD_LEN[i]) word_hit = 1'b1;
      end

      // fixed priority, first hit wins
      if (n_at_start)                           result.reason = REASON_EMPTY;
      else if (is_ws(n_first) || is_ws(n_prev)) result.reason = REASON_EDGE_WS;
      else if (is_lead_special(n_first))        result.reason = REASON_LEAD;
      else if (n_colon)                         result.reason = REASON_COLON;
      else if (word_hit)                        result.reason = REASON_WORD;
      else if (n_num == NS_INT || n_num == NS_FRAC || n_num == NS_EXPDIG ||
               n_num == NS_HEX || n_num == NS_OCT || n_num == NS_SPD)
         result.reason = REASON_NUMERIC;
      else
         result.reason = REASON_NONE;
      result.needs_quote = result.reason != REASON_NONE;

      // clear for the next scalar once this one closes
      if (take && ends) begin
         at_start_in = 1'b1;
         first_in    = 8'h00;
         prev_in     = 8'h00;
         colon_in    = 1'b0;
         alive_in    = '1;
         pos_in      = 3'd0;
         num_in      = NS_START;
      end else begin
         at_start_in = n_at_start;
         first_in    = n_first;
         prev_in     = n_prev;
         colon_in    = n_colon;
         alive_in    = n_alive;
         pos_in      = n_pos;
         num_in      = n_num;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
         first_ff    <= 8'h00;
         prev_ff     <= 8'h00;
         colon_ff    <= 1'b0;
         alive_ff    <= '1;
         pos_ff      <= 3'd0;
         num_ff      <= NS_START;
      end else begin
         at_start_ff <= at_start_in;
         first_ff    <= first_in;
         prev_ff     <= prev_in;
         colon_ff    <= colon_in;
         alive_ff    <= alive_in;
         pos_ff      <= pos_in;
         num_ff      <= num_in;
      end
   end

endmodule

// ----- hw/rtl/yqc_outbuf.sv -----
// ----------------------------------------------------------------------------
// yqc_outbuf
// Result register on the rsp_ side; holds one word until it is taken.
// ----------------------------------------------------------------------------
module yqc_outbuf
   import yqc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   logic       vld_ff, vld_in;
   result_type data_ff, data_in;

   always_comb begin
      free    = !vld_ff || rsp_ready;
      vld_in  = load ? 1'b1 : (rsp_ready ? 1'b0 : vld_ff);
      data_in = load ? load_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- hw/rtl/yaml_scalar_quote_classifier_top.sv -----
// ----------------------------------------------------------------------------
// yaml_scalar_quote_classifier_top
// Decides whether a YAML scalar, streamed one character per word, must be
// emitted double-quoted, and reports why.
// ----------------------------------------------------------------------------
// A scalar arrives as a run of req_ words, one byte each, closed by the word
// with req_last set; a word with req_empty_req set closes the scalar without
// adding its byte (an empty scalar if nothing came before). Each closed
// scalar yields exactly one rsp_ word: rsp_needs_quote and rsp_reason, where
// the reason is the first of empty, edge space/tab, leading ?-*&!|>%@,
// colon-space, true/false/null/yes/no/on/off (any case), numeric literal
// (decimal, float with exponent, 0x hex, 0o octal, .inf/.nan) that holds,
// or none. Words that do not close a scalar produce nothing. Throughput is
// one word per cycle when not stalled: a word waits in the input register
// while the scan logic updates the per-scalar state and, on a closing word,
// writes the verdict into the result register, which drives rsp_valid. The
// only stall is a closing word meeting a full result register that the
// consumer is not draining; while it waits, req_ready stays low and no
// further words are taken.
// ----------------------------------------------------------------------------
module yaml_scalar_quote_classifier_top
   import yqc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   input  logic       req_empty_req,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_needs_quote,
   output logic [2:0] rsp_reason
);

   // input register
   logic     in_vld_ff, in_vld_in;
   item_type in_item_ff, in_item_in;

   logic       ends;      // held word closes a scalar
   logic       process;   // held word is consumed this cycle
   logic       out_free;
   result_type verdict;
   result_type out_word;

   always_comb begin
      ends      = in_item_ff.last || in_item_ff.empty_req;
      // a closing word needs room in the result register
      process   = in_vld_ff && (!ends || out_free);
      req_ready = !in_vld_ff || process;

      if (req_valid && req_ready) begin
         in_vld_in  = 1'b1;
         in_item_in = '{ch: req_ch, last: req_last, empty_req: req_empty_req};
      end else begin
         in_vld_in  = in_vld_ff && !process;
         in_item_in = in_item_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      in_item_ff <= in_item_in;
   end

   // per-scalar state and verdict
   yqc_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .take   (process),
      .item   (in_item_ff),
      .result (verdict)
   );

   // result register
   yqc_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .load      (process && ends),
      .load_data (verdict),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (out_word)
   );

   assign rsp_needs_quote = out_word.needs_quote;
   assign rsp_reason      = out_word.reason;

endmodule

// ----- hw/rtl/yqc_checker.sv -----
// ----------------------------------------------------------------------------
// yqc_checker
// Port-level checks on the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module yqc_checker
   import yqc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_ch,
   input logic       req_last,
   input logic       req_empty_req,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_needs_quote,
   input logic [2:0] rsp_reason
);

   // no result word right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=>
         req_valid && $stable(req_ch) && $stable(req_last) && $stable(req_empty_req))
      else $error("request word changed while stalled");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_needs_quote) && $stable(rsp_reason))
      else $error("result word changed while stalled");

   // flag and reason agree
   a_flag_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_needs_quote == (rsp_reason != REASON_NONE)))
      else $error("needs_quote disagrees with reason");

   // reason within defined codes
   a_reason_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reason <= REASON_NUMERIC))
      else $error("undefined reason code");

endmodule

bind yaml_scalar_quote_classifier_top yqc_checker u_yqc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_ch          (req_ch),
   .req_last        (req_last),
   .req_empty_req   (req_empty_req),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_needs_quote (rsp_needs_quote),
   .rsp_reason      (rsp_reason)
);
